// ----- rtl/qsi_pkg.sv -----
// Shared widths, constants and transaction types of the quadratic subpixel interpolator.
`timescale 1ns / 1ps

package qsi_pkg;

    localparam int PIXEL_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int OUT_BITS   = 27;

    // Widths of the window sums and their products with the offset terms.
    localparam int GRAD_W   = PIXEL_BITS + 3;
    localparam int CURV_W   = PIXEL_BITS + 5;
    localparam int TWIST_W  = PIXEL_BITS + 2;
    localparam int SQ_W     = 2 * FRAC_BITS;
    localparam int PGRAD_W  = GRAD_W + FRAC_BITS;
    localparam int PCURV_W  = CURV_W + SQ_W;
    localparam int PTWIST_W = TWIST_W + SQ_W;

    // The full numerator, before the single rounding division.
    localparam int NUM_W = PIXEL_BITS + 2 * FRAC_BITS + 8;

    // The denominator is 15 * 2^DEN_SHIFT; the power of two goes first as a shift.
    localparam int DEN_SHIFT = 2 * FRAC_BITS - 7;
    localparam logic [NUM_W-1:0] HALF_DEN = NUM_W'(15) << (2 * FRAC_BITS - 8);

    // Dividend of the divide by 15, clamped so the result can reach 2^(OUT_BITS-1) at most.
    localparam int T_W   = OUT_BITS + 3;
    localparam int CMP_W = (NUM_W > T_W) ? NUM_W : T_W;
    localparam logic [T_W-1:0] T_MAX = T_W'(15) << (OUT_BITS - 1);

    // Reciprocal of 15, rounded up, exact for every dividend below 2^T_W.
    localparam int RECIP_SHIFT = T_W + 4;
    localparam int PROD_W      = 2 * T_W + 1;
    localparam logic [T_W:0] RECIP =
        (T_W + 1)'(((64'd1 << RECIP_SHIFT) + 64'd14) / 64'd15);

    localparam logic signed [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS - 1){1'b1}}};

    typedef logic signed [PIXEL_BITS-1:0] pix_t;
    typedef logic        [FRAC_BITS-1:0]  frac_t;
    typedef logic signed [FRAC_BITS-1:0]  off_t;
    typedef logic signed [SQ_W-1:0]       sq_t;
    typedef logic signed [GRAD_W-1:0]     grad_t;
    typedef logic signed [CURV_W-1:0]     curv_t;
    typedef logic signed [TWIST_W-1:0]    twist_t;
    typedef logic signed [PGRAD_W-1:0]    pgrad_t;
    typedef logic signed [PCURV_W-1:0]    pcurv_t;
    typedef logic signed [PTWIST_W-1:0]   ptwist_t;
    typedef logic signed [NUM_W-1:0]      num_t;
    typedef logic signed [OUT_BITS-1:0]   value_t;

    typedef struct packed {
        pix_t  pix_top_left;
        pix_t  pix_top_mid;
        pix_t  pix_top_right;
        pix_t  pix_mid_left;
        pix_t  pix_centre;
        pix_t  pix_mid_right;
        pix_t  pix_bot_left;
        pix_t  pix_bot_mid;
        pix_t  pix_bot_right;
        frac_t frac_x;
        frac_t frac_y;
        logic  window_inside;
    } qsi_in_t;

    typedef struct packed {
        value_t interp_value;
        logic   value_valid;
    } qsi_out_t;

    // Surface coefficients (as unscaled window sums) and the offset terms.
    typedef struct packed {
        pix_t   center;
        grad_t  grad_x;
        grad_t  grad_y;
        curv_t  curv_x;
        curv_t  curv_y;
        twist_t twist;
        off_t   off_x;
        off_t   off_y;
        sq_t    sq_x;
        sq_t    sq_y;
        sq_t    sq_xy;
        logic   in_region;
    } qsi_coef_t;

endpackage

// ----- rtl/qsi_coef.sv -----
// Window sums of the quadratic fit and the sample offset terms, first pipeline stage logic.
`timescale 1ns / 1ps

module qsi_coef
(
    input  qsi_pkg::qsi_in_t   sample,
    output qsi_pkg::qsi_coef_t coef
);

    qsi_pkg::curv_t p [3][3];
    qsi_pkg::curv_t gx;
    qsi_pkg::curv_t gy;
    qsi_pkg::curv_t tw;

    always_comb
    begin
        p[0][0] = qsi_pkg::curv_t'(sample.pix_top_left);
        p[0][1] = qsi_pkg::curv_t'(sample.pix_top_mid);
        p[0][2] = qsi_pkg::curv_t'(sample.pix_top_right);
        p[1][0] = qsi_pkg::curv_t'(sample.pix_mid_left);
        p[1][1] = qsi_pkg::curv_t'(sample.pix_centre);
        p[1][2] = qsi_pkg::curv_t'(sample.pix_mid_right);
        p[2][0] = qsi_pkg::curv_t'(sample.pix_bot_left);
        p[2][1] = qsi_pkg::curv_t'(sample.pix_bot_mid);
        p[2][2] = qsi_pkg::curv_t'(sample.pix_bot_right);
    end

    always_comb
    begin
        gx = (p[0][2] - p[0][0]) + (p[1][2] - p[1][0]) + (p[2][2] - p[2][0]);
        gy = (p[2][0] - p[0][0]) + (p[2][1] - p[0][1]) + (p[2][2] - p[0][2]);
        tw = p[0][0] - p[2][0] + p[2][2] - p[0][2];

        coef.center = sample.pix_centre;
        coef.grad_x = gx[qsi_pkg::GRAD_W-1:0];
        coef.grad_y = gy[qsi_pkg::GRAD_W-1:0];
        coef.twist  = tw[qsi_pkg::TWIST_W-1:0];

        // Curvature along x weights the rows 1-3-1, along y the columns 1-3-1.
        coef.curv_x = p[0][0] - (p[0][1] <<< 1) + p[0][2]
                    + (p[1][0] <<< 1) + p[1][0]
                    - (p[1][1] <<< 2) - (p[1][1] <<< 1)
                    + (p[1][2] <<< 1) + p[1][2]
                    + p[2][0] - (p[2][1] <<< 1) + p[2][2];
        coef.curv_y = p[0][0] + (p[0][1] <<< 1) + p[0][1] + p[0][2]
                    - (p[1][0] <<< 1)
                    - (p[1][1] <<< 2) - (p[1][1] <<< 1)
                    - (p[1][2] <<< 1)
                    + p[2][0] + (p[2][1] <<< 1) + p[2][1] + p[2][2];

        // frac - 2^(FRAC_BITS-1) is the fraction with its top bit inverted, read as signed.
        coef.off_x = {~sample.frac_x[qsi_pkg::FRAC_BITS-1], sample.frac_x[qsi_pkg::FRAC_BITS-2:0]};
        coef.off_y = {~sample.frac_y[qsi_pkg::FRAC_BITS-1], sample.frac_y[qsi_pkg::FRAC_BITS-2:0]};
        coef.sq_x  = qsi_pkg::sq_t'(coef.off_x) * qsi_pkg::sq_t'(coef.off_x);
        coef.sq_y  = qsi_pkg::sq_t'(coef.off_y) * qsi_pkg::sq_t'(coef.off_y);
        coef.sq_xy = qsi_pkg::sq_t'(coef.off_x) * qsi_pkg::sq_t'(coef.off_y);

        coef.in_region = sample.window_inside;
    end

endmodule

// ----- rtl/quadratic_subpixel_interpolator.sv -----
// Top level of the quadratic subpixel interpolator: seven-stage pipeline with per-stage stall.
`timescale 1ns / 1ps

// Takes one 3x3 window and a fractional sample position per transaction and returns the
// value of the fitted quadratic surface at that point, signed with 8 fraction bits,
// rounded to nearest (ties away from zero) and clamped; the value is zero and
// value_valid is low when window_inside is low. One transaction is accepted every
// cycle while sample_stall is low; each result passes through the seven register
// stages in order (window sums, products, scaling, numerator sum, rounding,
// multiply by the reciprocal of 15, output register). Each stage holds or advances
// on its own, so empty stages fill while the output is stalled, and sample_stall
// rises only when all seven stages hold data and result_stall is high.

module quadratic_subpixel_interpolator
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  qsi_pkg::qsi_in_t  sample,
    output logic              result_valid,
    input  logic              result_stall,
    output qsi_pkg::qsi_out_t result
);

    localparam int NSTG = 7;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;

    // Stage 0: window sums and offsets.
    qsi_pkg::qsi_coef_t s0_coef_next;
    qsi_pkg::qsi_coef_t s0_coef_reg;

    // Stage 1: products with the offset terms.
    qsi_pkg::pgrad_t  s1_gx_next, s1_gy_next, s1_gx_reg, s1_gy_reg;
    qsi_pkg::pcurv_t  s1_cx_next, s1_cy_next, s1_cx_reg, s1_cy_reg;
    qsi_pkg::ptwist_t s1_tw_next, s1_tw_reg;
    qsi_pkg::pix_t    s1_center_reg;
    logic             s1_inside_reg;

    // Stage 2: terms scaled to the common denominator.
    qsi_pkg::num_t s2_a_next, s2_bc_next, s2_df_next, s2_e_next;
    qsi_pkg::num_t s2_a_reg, s2_bc_reg, s2_df_reg, s2_e_reg;
    qsi_pkg::num_t bc_sum, df_sum, tw_ext, ct_ext;
    logic          s2_inside_reg;

    // Stage 3: numerator.
    qsi_pkg::num_t s3_num_next, s3_num_reg;
    logic          s3_inside_reg;

    // Stage 4: rounded magnitude, divided by the power of two, clamped.
    logic [qsi_pkg::NUM_W-1:0] mag, rnd;
    logic [qsi_pkg::CMP_W-1:0] scaled;
    logic [qsi_pkg::T_W-1:0]   s4_t_next, s4_t_reg;
    logic                      s4_neg_reg, s4_inside_reg;

    // Stage 5: multiply by the reciprocal of 15.
    logic [qsi_pkg::PROD_W-1:0] s5_prod_next, s5_prod_reg;
    logic                       s5_neg_reg, s5_inside_reg;

    // Stage 6: output register.
    logic [qsi_pkg::OUT_BITS-1:0] quo;
    qsi_pkg::qsi_out_t            result_next, result_reg;

    // A stage loads when it is empty or the stage after it moves on.
    assign en[NSTG-1] = !vld_reg[NSTG-1] || !result_stall;

    for (genvar k = 0; k < NSTG - 1; k++)
    begin : g_en
        assign en[k] = !vld_reg[k] || en[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= sample_valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign sample_stall = !en[0];
    assign result_valid = vld_reg[NSTG-1];
    assign result       = result_reg;

    qsi_coef u_coef
    (
        .sample (sample),
        .coef   (s0_coef_next)
    );

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_coef_reg <= s0_coef_next;
        end
    end

    always_comb
    begin
        s1_gx_next = qsi_pkg::pgrad_t'(s0_coef_reg.grad_x) * qsi_pkg::pgrad_t'(s0_coef_reg.off_x);
        s1_gy_next = qsi_pkg::pgrad_t'(s0_coef_reg.grad_y) * qsi_pkg::pgrad_t'(s0_coef_reg.off_y);
        s1_cx_next = qsi_pkg::pcurv_t'(s0_coef_reg.curv_x) * qsi_pkg::pcurv_t'(s0_coef_reg.sq_x);
        s1_cy_next = qsi_pkg::pcurv_t'(s0_coef_reg.curv_y) * qsi_pkg::pcurv_t'(s0_coef_reg.sq_y);
        s1_tw_next = qsi_pkg::ptwist_t'(s0_coef_reg.twist) * qsi_pkg::ptwist_t'(s0_coef_reg.sq_xy);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_gx_reg     <= s1_gx_next;
            s1_gy_reg     <= s1_gy_next;
            s1_cx_reg     <= s1_cx_next;
            s1_cy_reg     <= s1_cy_next;
            s1_tw_reg     <= s1_tw_next;
            s1_center_reg <= s0_coef_reg.center;
            s1_inside_reg <= s0_coef_reg.in_region;
        end
    end

    // Numerator = 30*2^(2F)*center + 5*2^F*(gradient terms) + 6*(curvature terms)
    // + 15*(twist term), all over 15*2^(2F-7).
    always_comb
    begin
        bc_sum     = qsi_pkg::num_t'(s1_gx_reg) + qsi_pkg::num_t'(s1_gy_reg);
        df_sum     = qsi_pkg::num_t'(s1_cx_reg) + qsi_pkg::num_t'(s1_cy_reg);
        tw_ext     = qsi_pkg::num_t'(s1_tw_reg);
        ct_ext     = qsi_pkg::num_t'(s1_center_reg);
        s2_bc_next = (bc_sum <<< 2) + bc_sum;
        s2_df_next = (df_sum <<< 2) + (df_sum <<< 1);
        s2_e_next  = (tw_ext <<< 4) - tw_ext;
        s2_a_next  = (ct_ext <<< 5) - (ct_ext <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_a_reg      <= s2_a_next;
            s2_bc_reg     <= s2_bc_next;
            s2_df_reg     <= s2_df_next;
            s2_e_reg      <= s2_e_next;
            s2_inside_reg <= s1_inside_reg;
        end
    end

    always_comb
    begin
        s3_num_next = (s2_a_reg <<< (2 * qsi_pkg::FRAC_BITS))
                    + (s2_bc_reg <<< qsi_pkg::FRAC_BITS)
                    + s2_df_reg + s2_e_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_num_reg    <= s3_num_next;
            s3_inside_reg <= s2_inside_reg;
        end
    end

    // Round half away from zero on the magnitude; larger results saturate anyway,
    // so the dividend is clamped to keep the divide by 15 narrow.
    always_comb
    begin
        mag       = s3_num_reg[qsi_pkg::NUM_W-1] ? (~s3_num_reg + 1'b1) : s3_num_reg;
        rnd       = mag + qsi_pkg::HALF_DEN;
        scaled    = qsi_pkg::CMP_W'(rnd >> qsi_pkg::DEN_SHIFT);
        s4_t_next = (scaled > qsi_pkg::CMP_W'(qsi_pkg::T_MAX)) ?
                    qsi_pkg::T_MAX : scaled[qsi_pkg::T_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_t_reg      <= s4_t_next;
            s4_neg_reg    <= s3_num_reg[qsi_pkg::NUM_W-1];
            s4_inside_reg <= s3_inside_reg;
        end
    end

    always_comb
    begin
        s5_prod_next = qsi_pkg::PROD_W'(s4_t_reg) * qsi_pkg::PROD_W'(qsi_pkg::RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_prod_reg   <= s5_prod_next;
            s5_neg_reg    <= s4_neg_reg;
            s5_inside_reg <= s4_inside_reg;
        end
    end

    always_comb
    begin
        quo                     = s5_prod_reg[qsi_pkg::PROD_W-1:qsi_pkg::RECIP_SHIFT];
        result_next.value_valid = s5_inside_reg;
        if (!s5_inside_reg)
        begin
            result_next.interp_value = '0;
        end
        else if (s5_neg_reg)
        begin
            result_next.interp_value = ~quo + 1'b1;
        end
        else if (quo[qsi_pkg::OUT_BITS-1])
        begin
            result_next.interp_value = qsi_pkg::OUT_MAX;
        end
        else
        begin
            result_next.interp_value = quo;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            result_reg <= result_next;
        end
    end

endmodule

// ----- rtl/qsi_checker.sv -----
// Port-level checks of the quadratic subpixel interpolator and their bind to the top level.
`timescale 1ns / 1ps

module qsi_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              sample_stall,
    input logic              result_valid,
    input logic              result_stall,
    input qsi_pkg::qsi_out_t result
);

    // A stalled result transaction stays put.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed or vanished");

    // The input side backs up only when the output is full and held.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> result_valid && result_stall)
        else $error("sample stalled while the output could drain");

    // A window outside the region gives a zero value.
    a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.value_valid |-> result.interp_value == '0)
        else $error("nonzero value for a window outside the region");

endmodule

bind quadratic_subpixel_interpolator qsi_checker u_qsi_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// ----- tb/quadratic_subpixel_interpolator_test.sv -----
// Self-checking testbench of the quadratic subpixel interpolator.
`timescale 1ns / 1ps

module quadratic_subpixel_interpolator_test;

    localparam int  CYCLE_LIMIT  = 200000;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  TAIL_CYCLES  = 20;
    localparam int  ERROR_LINES  = 200;
    localparam qsi_pkg::pix_t PIX_MAX    = 16'sh7fff;
    localparam qsi_pkg::pix_t PIX_MIN    = 16'sh8000;
    localparam qsi_pkg::frac_t FRAC_HALF = qsi_pkg::frac_t'(1 << (qsi_pkg::FRAC_BITS - 1));

    logic              clk;
    logic              rst_n        = 1'b0;
    logic              sample_valid = 1'b0;
    logic              sample_stall;
    qsi_pkg::qsi_in_t  sample       = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    qsi_pkg::qsi_out_t result;

    qsi_pkg::qsi_out_t pending_values[$];
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;
    logic     hold_start     = 1'b0;
    int       hold_left      = 0;

    quadratic_subpixel_interpolator uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Value of the fitted surface at the sample point, formed as one exact numerator
    // over 120 * half^2 and rounded once to 1/256 units.
    function automatic qsi_pkg::qsi_out_t surface_value(input qsi_pkg::qsi_in_t s);
        longint            p00, p01, p02, p10, p11, p12, p20, p21, p22;
        longint            half, u, v, sum_gx, sum_gy, sum_cx, sum_cy, sum_tw, num, den, res;
        longint unsigned   mag, q;
        qsi_pkg::qsi_out_t r;
        r = '0;
        if (!s.window_inside)
            return r;
        p00 = longint'(s.pix_top_left);
        p01 = longint'(s.pix_top_mid);
        p02 = longint'(s.pix_top_right);
        p10 = longint'(s.pix_mid_left);
        p11 = longint'(s.pix_centre);
        p12 = longint'(s.pix_mid_right);
        p20 = longint'(s.pix_bot_left);
        p21 = longint'(s.pix_bot_mid);
        p22 = longint'(s.pix_bot_right);
        half = longint'(1) << (qsi_pkg::FRAC_BITS - 1);
        u = longint'({1'b0, s.frac_x}) - half;
        v = longint'({1'b0, s.frac_y}) - half;
        sum_gx = (p02 - p00) + (p12 - p10) + (p22 - p20);
        sum_gy = (p20 - p00) + (p21 - p01) + (p22 - p02);
        sum_cx = p00 - 2 * p01 + p02 + 3 * p10 - 6 * p11 + 3 * p12 + p20 - 2 * p21 + p22;
        sum_tw = p00 - p20 + p22 - p02;
        sum_cy = p00 + 3 * p01 + p02 - 2 * p10 - 6 * p11 - 2 * p12 + p20 + 3 * p21 + p22;
        num = p11 * (longint'(30) << (2 * qsi_pkg::FRAC_BITS))
            + 10 * half * (sum_gx * u + sum_gy * v)
            + 6 * (sum_cx * u * u + sum_cy * v * v)
            + 15 * sum_tw * u * v;
        den = longint'(15) << (2 * qsi_pkg::FRAC_BITS - 7);
        mag = (num < 0) ? longint'(0) - num : num;
        q = (mag + den / 2) / den;
        if (q > (longint'(1) << (qsi_pkg::OUT_BITS - 1)))
            q = longint'(1) << (qsi_pkg::OUT_BITS - 1);
        res = (num < 0) ? -longint'(q) : longint'(q);
        if (res > (longint'(1) << (qsi_pkg::OUT_BITS - 1)) - 1)
            res = (longint'(1) << (qsi_pkg::OUT_BITS - 1)) - 1;
        r.interp_value = qsi_pkg::value_t'(res);
        r.value_valid  = 1'b1;
        return r;
    endfunction

    function automatic qsi_pkg::qsi_in_t make_window(
        input qsi_pkg::pix_t tl, input qsi_pkg::pix_t tm, input qsi_pkg::pix_t tr,
        input qsi_pkg::pix_t ml, input qsi_pkg::pix_t c, input qsi_pkg::pix_t mr,
        input qsi_pkg::pix_t bl, input qsi_pkg::pix_t bm, input qsi_pkg::pix_t br,
        input qsi_pkg::frac_t fx, input qsi_pkg::frac_t fy,
        input logic in_region);
        qsi_pkg::qsi_in_t s;
        s.pix_top_left  = tl;
        s.pix_top_mid   = tm;
        s.pix_top_right = tr;
        s.pix_mid_left  = ml;
        s.pix_centre    = c;
        s.pix_mid_right = mr;
        s.pix_bot_left  = bl;
        s.pix_bot_mid   = bm;
        s.pix_bot_right = br;
        s.frac_x        = fx;
        s.frac_y        = fy;
        s.window_inside = in_region;
        return s;
    endfunction

    function automatic qsi_pkg::frac_t random_frac();
        qsi_pkg::frac_t picks[7];
        picks = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
        if ($urandom_range(0, 3) != 0)
            return qsi_pkg::frac_t'($urandom);
        return picks[$urandom_range(0, 6)];
    endfunction

    // Smooth patches around a random level, fully random windows, extreme windows, or a per-pixel mix of the three.
    function automatic qsi_pkg::qsi_in_t random_sample();
        qsi_pkg::pix_t w[9];
        int   mode, pick, base, spread, val, k;
        mode   = $urandom_range(0, 9);
        base   = int'($urandom_range(0, 65535)) - 32768;
        spread = 1 << $urandom_range(0, 12);
        for (k = 0; k < 9; k++)
        begin
            pick = (mode == 9) ? $urandom_range(0, 8) : mode;
            if (pick <= 3)
            begin
                val = base + int'($urandom_range(0, 2 * spread)) - spread;
                if (val > 32767)
                    val = 32767;
                if (val < -32768)
                    val = -32768;
                w[k] = qsi_pkg::pix_t'(val);
            end
            else if (pick <= 6)
                w[k] = qsi_pkg::pix_t'($urandom);
            else
                w[k] = $urandom_range(0, 1) ? PIX_MAX : PIX_MIN;
        end
        return make_window(w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], w[8],
                           random_frac(), random_frac(), $urandom_range(0, 9) != 0);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < ERROR_LINES)
            $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
                     want);
        mismatch_count++;
    endtask

    // Valid is only lowered while idling, so a back-to-back transaction keeps it high.
    task automatic send_sample(input qsi_pkg::qsi_in_t item);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= item;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        pending_values.push_back(surface_value(item));
    endtask

    task automatic wait_until_drained();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending_values.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random(input int count);
        int k;
        for (k = 0; k < count; k++)
            send_sample(random_sample());
    endtask

    task automatic test_directed_corners();
        send_sample(make_window('0, '0, '0, '0, '0, '0, '0, '0, '0, 8'd0, 8'd0, 1'b1));
        send_sample(make_window(PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX,
                                PIX_MAX, PIX_MAX, PIX_MAX, 8'd255, 8'd255, 1'b1));
        send_sample(make_window(PIX_MIN, PIX_MIN, PIX_MIN, PIX_MIN, PIX_MIN, PIX_MIN,
                                PIX_MIN, PIX_MIN, PIX_MIN, 8'd0, 8'd0, 1'b1));
        send_sample(make_window(PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX,
                                PIX_MAX, PIX_MAX, PIX_MAX, 8'd0, 8'd255, 1'b1));
        send_sample(make_window(PIX_MIN, PIX_MIN, PIX_MIN, PIX_MIN, PIX_MIN, PIX_MIN,
                                PIX_MIN, PIX_MIN, PIX_MIN, 8'd255, 8'd0, 1'b1));
        // Checkerboards give equal curvatures along x and y with zero gradients and twist.
        send_sample(make_window(PIX_MAX, PIX_MIN, PIX_MAX, PIX_MIN, PIX_MAX, PIX_MIN,
                                PIX_MAX, PIX_MIN, PIX_MAX, 8'd0, 8'd0, 1'b1));
        send_sample(make_window(PIX_MIN, PIX_MAX, PIX_MIN, PIX_MAX, PIX_MIN, PIX_MAX,
                                PIX_MIN, PIX_MAX, PIX_MIN, 8'd255, 8'd255, 1'b1));
        send_sample(make_window(PIX_MAX, PIX_MIN, PIX_MAX, PIX_MIN, PIX_MAX, PIX_MIN,
                                PIX_MAX, PIX_MIN, PIX_MAX, 8'd0, 8'd255, 1'b1));
        send_sample(make_window('0, '0, '0, '0, PIX_MAX, '0, '0, '0, '0,
                                FRAC_HALF, FRAC_HALF, 1'b1));
        send_sample(make_window(PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MIN, PIX_MAX,
                                PIX_MAX, PIX_MAX, PIX_MAX, 8'd127, 8'd129, 1'b1));
        // Steepest gradients along x and along y.
        send_sample(make_window(PIX_MIN, '0, PIX_MAX, PIX_MIN, '0, PIX_MAX,
                                PIX_MIN, '0, PIX_MAX, 8'd0, 8'd128, 1'b1));
        send_sample(make_window(PIX_MIN, '0, PIX_MAX, PIX_MIN, '0, PIX_MAX,
                                PIX_MIN, '0, PIX_MAX, 8'd255, 8'd1, 1'b1));
        send_sample(make_window(PIX_MIN, PIX_MIN, PIX_MIN, '0, '0, '0,
                                PIX_MAX, PIX_MAX, PIX_MAX, 8'd128, 8'd255, 1'b1));
        // Corners on one diagonal at the maximum and on the other at the minimum give the largest cross term.
        send_sample(make_window(PIX_MAX, '0, PIX_MIN, '0, '0, '0,
                                PIX_MIN, '0, PIX_MAX, 8'd0, 8'd0, 1'b1));
        send_sample(make_window(PIX_MAX, '0, PIX_MIN, '0, '0, '0,
                                PIX_MIN, '0, PIX_MAX, 8'd255, 8'd0, 1'b1));
        wait_until_drained();
    endtask

    // Each of these windows lands exactly half way between two output codes.
    task automatic test_rounding_ties();
        send_sample(make_window(16'sd320, '0, 16'sd320, '0, '0, '0, '0, '0, '0,
                                8'd129, 8'd128, 1'b1));
        send_sample(make_window(-16'sd320, '0, -16'sd320, '0, '0, '0, '0, '0, '0,
                                8'd129, 8'd128, 1'b1));
        send_sample(make_window(16'sd320, '0, '0, '0, '0, '0, 16'sd320, '0, '0,
                                8'd128, 8'd129, 1'b1));
        send_sample(make_window(-16'sd320, '0, '0, '0, '0, '0, -16'sd320, '0, '0,
                                8'd128, 8'd129, 1'b1));
        wait_until_drained();
    endtask

    task automatic test_window_outside();
        send_sample(make_window(PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX,
                                PIX_MAX, PIX_MAX, PIX_MAX, 8'd255, 8'd255, 1'b0));
        send_sample(make_window(PIX_MIN, PIX_MAX, PIX_MIN, PIX_MAX, PIX_MIN, PIX_MAX,
                                PIX_MIN, PIX_MAX, PIX_MIN, 8'd0, 8'd0, 1'b0));
        send_sample(make_window(PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX,
                                PIX_MAX, PIX_MAX, PIX_MAX, 8'd255, 8'd255, 1'b1));
        wait_until_drained();
    endtask

    task automatic test_random_streaming();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random(90);
        wait_until_drained();
    endtask

    task automatic test_random_sender_gaps();
        send_idle_pct  = 88;
        recv_stall_pct = 0;
        send_random(90);
        wait_until_drained();
    endtask

    task automatic test_random_receiver_stalls();
        send_idle_pct  = 0;
        recv_stall_pct = 88;
        send_random(90);
        wait_until_drained();
    endtask

    task automatic test_random_both_idle();
        send_idle_pct  = 12;
        recv_stall_pct = 12;
        send_random(90);
        wait_until_drained();
    endtask

    // The receiver holds off long enough for the pipeline to fill and stall its input.
    task automatic test_backpressure_hold();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        send_random(40);
        wait_until_drained();
    endtask

    task automatic test_pause_until_empty();
        int k;
        send_idle_pct  = 12;
        recv_stall_pct = 12;
        for (k = 0; k < 3; k++)
        begin
            send_random(8);
            wait_until_drained();
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_start)
            hold_left <= HOLD_CYCLES;
    end

    always @(posedge clk)
    begin
        qsi_pkg::qsi_out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_values.size() == 0)
                report_mismatch("result with no sample waiting, interp_value",
                                longint'(result.interp_value), 0);
            else
            begin
                want = pending_values.pop_front();
                if (result.interp_value !== want.interp_value)
                    report_mismatch("interp_value", longint'(result.interp_value),
                                    longint'(want.interp_value));
                if (result.value_valid !== want.value_valid)
                    report_mismatch("value_valid", longint'(result.value_valid),
                                    longint'(want.value_valid));
            end
        end
        result_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_corners();
        test_rounding_ties();
        test_window_outside();
        test_random_streaming();
        test_random_sender_gaps();
        test_random_receiver_stalls();
        test_random_both_idle();
        test_backpressure_hold();
        test_pause_until_empty();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
